/* hw/rtl/srgf_pkg.sv */
// ----------------------------------------------------------------------------
// srgf_pkg
// Shared types and codes of the sequence reorder / gap fill buffer.
// ----------------------------------------------------------------------------
package srgf_pkg;

  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int CNT32_W  = 32;

  // item kinds on the result channel
  localparam logic [1:0] KIND_CHUNK   = 2'd0;
  localparam logic [1:0] KIND_SILENCE = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // status codes
  localparam logic [1:0] CODE_OK      = 2'd0;
  localparam logic [1:0] CODE_OOO     = 2'd1;
  localparam logic [1:0] CODE_LATE    = 2'd2;
  localparam logic [1:0] CODE_BEYOND  = 2'd3;

  // input opcodes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // configuration port
  localparam int   CFG_ADDR_W     = 3;
  localparam int   CFG_DATA_W     = 32;
  localparam logic REG_SILENCE_EN = 1'b0;

  typedef struct packed {
    logic load;         // capture the accepted item
    logic eval;         // classify item and update window
    logic rd;           // read handle store at head
    logic emit_chunk;   // send chunk at head and advance
    logic skip_gap;     // count missing number, maybe send silence, advance
    logic emit_status;  // send closing status item
  } cmd_t;

  typedef struct packed {
    logic op_drain;
    logic reject;       // late or beyond window
    logic head_valid;
    logic any_held;
    logic out_free;
    logic fill_on;
  } sts_t;

endpackage

/* hw/rtl/srgf_ctrl.sv */
// ----------------------------------------------------------------------------
// srgf_ctrl
// Sequencer: steps the datapath through classify, in-order run and drain.
// ----------------------------------------------------------------------------
module srgf_ctrl
  import srgf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EVAL    = 8'b0000_0010,
    ST_RUN     = 8'b0000_0100,
    ST_RUN_OUT = 8'b0000_1000,
    ST_DRN     = 8'b0001_0000,
    ST_DRN_OUT = 8'b0010_0000,
    ST_STAT    = 8'b0100_0000,
    ST_SPARE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.op_drain) begin
          state_nxt = ST_DRN;
        end else if (sts.reject) begin
          state_nxt = ST_STAT;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.head_valid) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_RUN_OUT;
        end else begin
          state_nxt = ST_STAT;
        end
      end
      ST_RUN_OUT: begin
        if (sts.out_free) begin
          cmd.emit_chunk = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      ST_DRN: begin
        if (sts.any_held) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_DRN_OUT;
        end else begin
          state_nxt = ST_STAT;
        end
      end
      ST_DRN_OUT: begin
        if (sts.head_valid) begin
          if (sts.out_free) begin
            cmd.emit_chunk = 1'b1;
            state_nxt      = ST_DRN;
          end
        end else if (!sts.fill_on || sts.out_free) begin
          cmd.skip_gap = 1'b1;
          state_nxt    = ST_DRN;
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/srgf_dp.sv */
// ----------------------------------------------------------------------------
// srgf_dp
// Datapath: window slots, handle store, sequence tracking, totals and the
// result register.
// ----------------------------------------------------------------------------
module srgf_dp
  import srgf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
)(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                silence_en,
  input  logic                in_opcode,
  input  logic [SEQ_W-1:0]    in_seq_number,
  input  logic [HANDLE_W-1:0] in_payload_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_item_kind,
  output logic [SEQ_W-1:0]    out_item_seq,
  output logic [HANDLE_W-1:0] out_item_handle,
  output logic [1:0]          out_status_code,
  output logic [CNT32_W-1:0]  out_ooo_count,
  output logic [CNT32_W-1:0]  out_gap_count,
  output logic                out_last
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

  // captured item
  logic                op_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [HANDLE_W-1:0] handle_r;

  // window state
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        held_r, held_nxt;
  logic [SEQ_W-1:0]        exp_r, exp_nxt;
  logic                    started_r, started_nxt;
  logic [CNT32_W-1:0]      ooo_r, ooo_nxt;
  logic [CNT32_W-1:0]      gap_r, gap_nxt;
  logic [1:0]              code_r, code_nxt;

  // handle store
  logic [HANDLE_W-1:0] mem [WINDOW_DEPTH];
  logic [HANDLE_W-1:0] rd_data_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;

  // result register
  logic                out_valid_r;
  logic [1:0]          kind_r;
  logic [SEQ_W-1:0]    oseq_r;
  logic [HANDLE_W-1:0] ohandle_r;
  logic [1:0]          ocode_r;
  logic [CNT32_W-1:0]  oooo_r;
  logic [CNT32_W-1:0]  ogap_r;
  logic                olast_r;
  logic                out_free;
  logic                out_load;

  // classification
  logic [SEQ_W-1:0] seq_diff;
  logic             late;
  logic             beyond;
  logic [IDX_W:0]   idx_sum;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] head_inc;

  assign seq_diff = seq_r - exp_r;
  assign late     = seq_diff[SEQ_W-1];
  assign beyond   = !late && (seq_diff >= SEQ_W'(WINDOW_DEPTH));
  assign idx_sum  = {1'b0, head_r} + {1'b0, seq_diff[IDX_W-1:0]};
  assign idx      = (idx_sum >= DEPTH_EXT) ? IDX_W'(idx_sum - DEPTH_EXT)
                                           : idx_sum[IDX_W-1:0];
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.emit_chunk || (cmd.skip_gap && silence_en) || cmd.emit_status;

  assign sts.op_drain   = (op_r == OP_DRAIN);
  assign sts.reject     = started_r && (op_r == OP_PACKET) && (late || beyond);
  assign sts.head_valid = valid_r[head_r];
  assign sts.any_held   = (held_r != '0);
  assign sts.out_free   = out_free;
  assign sts.fill_on    = silence_en;

  always_comb begin
    valid_nxt   = valid_r;
    head_nxt    = head_r;
    held_nxt    = held_r;
    exp_nxt     = exp_r;
    started_nxt = started_r;
    ooo_nxt     = ooo_r;
    gap_nxt     = gap_r;
    code_nxt    = code_r;
    mem_we      = 1'b0;
    mem_waddr   = head_r;

    if (cmd.load) begin
      code_nxt = CODE_OK;
    end

    if (cmd.eval && (op_r == OP_PACKET)) begin
      if (!started_r) begin
        // first packet fixes the expected number
        started_nxt       = 1'b1;
        exp_nxt           = seq_r;
        mem_we            = 1'b1;
        mem_waddr         = head_r;
        valid_nxt[head_r] = 1'b1;
        held_nxt          = held_r + 1'b1;
      end else if (late) begin
        code_nxt = CODE_LATE;
      end else if (beyond) begin
        code_nxt = CODE_BEYOND;
      end else begin
        if (seq_diff != '0) begin
          code_nxt = CODE_OOO;
          if (ooo_r != '1) begin
            ooo_nxt = ooo_r + 1'b1;
          end
        end
        // duplicate of a waiting packet keeps the first handle
        if (!valid_r[idx]) begin
          mem_we         = 1'b1;
          mem_waddr      = idx;
          valid_nxt[idx] = 1'b1;
          held_nxt       = held_r + 1'b1;
        end
      end
    end

    if (cmd.emit_chunk) begin
      valid_nxt[head_r] = 1'b0;
      held_nxt          = held_r - 1'b1;
      head_nxt          = head_inc;
      exp_nxt           = exp_r + 1'b1;
    end

    if (cmd.skip_gap) begin
      if (gap_r != '1) begin
        gap_nxt = gap_r + 1'b1;
      end
      head_nxt = head_inc;
      exp_nxt  = exp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= '0;
      held_r      <= '0;
      exp_r       <= '0;
      started_r   <= 1'b0;
      ooo_r       <= '0;
      gap_r       <= '0;
      code_r      <= CODE_OK;
    end else begin
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      exp_r       <= exp_nxt;
      started_r   <= started_nxt;
      ooo_r       <= ooo_nxt;
      gap_r       <= gap_nxt;
      code_r      <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      seq_r    <= in_seq_number;
      handle_r <= in_payload_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= handle_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[head_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      oseq_r    <= exp_r;
      ohandle_r <= '0;
      ocode_r   <= CODE_OK;
      oooo_r    <= '0;
      ogap_r    <= '0;
      olast_r   <= 1'b0;
      if (cmd.emit_chunk) begin
        kind_r    <= KIND_CHUNK;
        ohandle_r <= rd_data_r;
      end else if (cmd.emit_status) begin
        kind_r  <= KIND_STATUS;
        ocode_r <= code_r;
        oooo_r  <= ooo_r;
        ogap_r  <= gap_r;
        olast_r <= 1'b1;
      end else begin
        kind_r <= KIND_SILENCE;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = kind_r;
  assign out_item_seq    = oseq_r;
  assign out_item_handle = ohandle_r;
  assign out_status_code = ocode_r;
  assign out_ooo_count   = oooo_r;
  assign out_gap_count   = ogap_r;
  assign out_last        = olast_r;

endmodule

/* hw/rtl/seq_reorder_gap_fill_buffer_unit.sv */
// ----------------------------------------------------------------------------
// seq_reorder_gap_fill_buffer_unit
// Reorders packet handles by 16-bit sequence number with a drain that fills
// missing numbers with silence items if fill is on; APB-style config port.
// ----------------------------------------------------------------------------
// order: a late or out-of-window packet passes the evaluate and status states;
//   a packet releasing chunks reads and sends each, then sends its status item.
// throughput: one item at a time; a drain walks slots from the head until none
//   is held, each visit a store read, then a chunk or (fill on) a silence item.
// reset: synchronous active-low; window empty, counters zero, fill on.
// ----------------------------------------------------------------------------
module seq_reorder_gap_fill_buffer_unit
  import srgf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [SEQ_W-1:0]      in_seq_number,
  input  logic [HANDLE_W-1:0]   in_payload_handle,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_item_kind,
  output logic [SEQ_W-1:0]      out_item_seq,
  output logic [HANDLE_W-1:0]   out_item_handle,
  output logic [1:0]            out_status_code,
  output logic [CNT32_W-1:0]    out_ooo_count,
  output logic [CNT32_W-1:0]    out_gap_count,
  output logic                  out_last,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cmd_t cmd;
  sts_t sts;
  logic fill_r, fill_nxt;
  logic reg_idx;
  logic wr_en;

  // word index of the register
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (reg_idx == REG_SILENCE_EN)) begin
      fill_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 1'b1;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == REG_SILENCE_EN) ? {{(CFG_DATA_W-1){1'b0}}, fill_r} : '0;

  srgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srgf_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .silence_en        (fill_r),
    .in_opcode         (in_opcode),
    .in_seq_number     (in_seq_number),
    .in_payload_handle (in_payload_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_item_seq      (out_item_seq),
    .out_item_handle   (out_item_handle),
    .out_status_code   (out_status_code),
    .out_ooo_count     (out_ooo_count),
    .out_gap_count     (out_gap_count),
    .out_last          (out_last)
  );

endmodule
